### rtl/olte_pkg.sv
// shared constants, codes and port structs of the ordered list table engine
package olte_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int ENTRY_W  = 7;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_HEAD    = 3'd0;
  localparam action_t ACT_TAIL    = 3'd1;
  localparam action_t ACT_AFTER   = 3'd2;
  localparam action_t ACT_ORDERED = 3'd3;
  localparam action_t ACT_REMOVE  = 3'd4;
  localparam action_t ACT_SEARCH  = 3'd5;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_MISS = 2'd2;

  // table memory write port
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] data;
  } wr_port_t;

  // table memory read port
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } rd_port_t;

endpackage

### rtl/olte_in_if.sv
// request channel: operation code and operand values
interface olte_in_if import olte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] reference_value;

  modport source (output valid, action, item_value, reference_value, input ready);
  modport sink (input valid, action, item_value, reference_value, output ready);
endinterface

### rtl/olte_out_if.sv
// response channel: status, value, position and entry count
interface olte_out_if import olte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] result_value;
  logic [POS_W-1:0]         position;
  logic [ENTRY_W-1:0]       entry_count;

  modport source (output valid, status, result_value, position, entry_count, input ready);
  modport sink (input valid, status, result_value, position, entry_count, output ready);
endinterface

### rtl/olte_ram.sv
// table memory: one write port, one read port with registered read data
module olte_ram import olte_pkg::*; (
  input  logic                     clk,
  input  wr_port_t                 wr,
  input  rd_port_t                 rd,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [CAPACITY];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/olte_ctrl.sv
// sequencer: walks the table memory at most once per operation, shifting entries in flight
module olte_ctrl import olte_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  olte_in_if.sink                  req,
  olte_out_if.source               rsp,
  output wr_port_t                 wr,
  output rd_port_t                 rd,
  input  logic signed [DATA_W-1:0] rd_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_REPLY  = 4'b1000
  } state_t;

  state_t                   state;
  action_t                  action;
  logic signed [DATA_W-1:0] item;
  logic signed [DATA_W-1:0] ref_val;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         rd_idx;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_k;
  logic                     hit;
  logic                     after_pend;
  logic signed [DATA_W-1:0] carry;
  logic [IDX_W-1:0]         pos;
  logic signed [DATA_W-1:0] rval;
  status_t                  res_status;

  logic                     out_valid;
  status_t                  out_status;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0]         out_pos;
  logic [ENTRY_W-1:0]       out_count;

  logic is_insert;
  logic is_full;
  logic ins_here;
  logic match_item;
  logic match_ref;
  logic item_less;
  logic item_greater;
  logic search_hit;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.result_value = out_value;
  assign rsp.position     = out_pos;
  assign rsp.entry_count  = out_count;

  // operation class and compares against the entry just read
  assign is_insert    = action inside {ACT_HEAD, ACT_TAIL, ACT_AFTER, ACT_ORDERED};
  assign is_full      = (count == CNT_W'(CAPACITY));
  assign match_item   = (rd_data == item);
  assign match_ref    = (rd_data == ref_val);
  assign item_less    = (item < rd_data);
  assign item_greater = (item > rd_data);
  assign search_hit   = rd_vld && !hit && match_item && (action == ACT_SEARCH);

  // read port walks ascending indices below count
  assign rd.re   = (state == S_SCAN) && (rd_idx < count);
  assign rd.addr = rd_idx[IDX_W-1:0];

  // insert point and write-back of shifted entries
  always_comb begin
    ins_here = 1'b0;
    wr.we    = 1'b0;
    wr.addr  = rd_k;
    wr.data  = carry;
    if (state == S_SCAN && rd_vld) begin
      case (action)
        ACT_HEAD:    ins_here = !hit;
        ACT_AFTER:   ins_here = !hit && after_pend;
        ACT_ORDERED: ins_here = !hit && ((rd_k == '0) ? item_less : !item_greater);
        default:     ins_here = 1'b0;
      endcase
      if (is_insert) begin
        if (hit) begin
          wr.we = 1'b1;
        end else if (ins_here) begin
          wr.we   = 1'b1;
          wr.data = item;
        end
      end else if (action == ACT_REMOVE && hit) begin
        wr.we   = 1'b1;
        wr.addr = IDX_W'(rd_k - 1'b1);
        wr.data = rd_data;
      end
    end else if (state == S_FINISH && is_insert && !is_full) begin
      // last displaced entry, or the new item at the tail
      wr.we   = 1'b1;
      wr.addr = count[IDX_W-1:0];
      wr.data = hit ? carry : item;
    end
  end

  // response valid flag: set when the result is loaded, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_REPLY && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            action     <= req.action;
            item       <= req.item_value;
            ref_val    <= req.reference_value;
            hit        <= 1'b0;
            after_pend <= 1'b0;
            pos        <= '0;
            rval       <= '0;
            rd_vld     <= 1'b0;
            // tail insert, insert into a full table and unused codes skip the walk
            if (req.action == ACT_TAIL || req.action > ACT_SEARCH ||
                (req.action <= ACT_ORDERED && is_full)) begin
              rd_idx <= count;
            end else begin
              rd_idx <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= rd.re && !search_hit;
          rd_k   <= rd_idx[IDX_W-1:0];
          if (rd.re) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_vld) begin
            if (is_insert) begin
              if (hit || ins_here) begin
                carry <= rd_data;
              end
              if (ins_here) begin
                hit <= 1'b1;
                pos <= rd_k;
              end
              if (action == ACT_AFTER && !after_pend && match_ref) begin
                after_pend <= 1'b1;
              end
            end else if (!hit && match_item) begin
              hit  <= 1'b1;
              pos  <= rd_k;
              rval <= rd_data;
            end
          end
          if (search_hit || (!rd.re && !rd_vld)) begin
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (is_insert) begin
            if (is_full) begin
              res_status <= STAT_FULL;
            end else begin
              res_status <= STAT_OK;
              count      <= count + 1'b1;
              if (!hit) begin
                pos <= count[IDX_W-1:0];
              end
            end
          end else if ((action == ACT_REMOVE || action == ACT_SEARCH) && hit) begin
            res_status <= STAT_OK;
            if (action == ACT_REMOVE) begin
              count <= count - 1'b1;
            end
          end else begin
            res_status <= STAT_MISS;
          end
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (!out_valid || rsp.ready) begin
            out_status <= res_status;
            out_value  <= rval;
            out_pos    <= POS_W'(pos);
            out_count  <= ENTRY_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // count moves only in the finish step
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINISH) |=> $stable(count))
    else $error("entry count changed outside finish");

  // an accepted insert into a non-full table adds exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && is_insert && !is_full) |=>
      (count == CNT_W'($past(count) + 1'b1)))
    else $error("insert did not add one entry");

  // read and write never meet on the same entry in one cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr.we && rd.re) |-> (wr.addr != rd.addr))
    else $error("read and write collide on one entry");

  // a search leaves the table memory untouched
  a_search_ro: assert property (@(posedge clk) disable iff (rst)
    (action == ACT_SEARCH) |-> !wr.we)
    else $error("search wrote the table");

endmodule

### rtl/ordered_list_table_engine_top.sv
// Ordered list table engine: top level with sequencer and table memory.
// The walk reads one table entry per cycle through the single read port.
// Search stops at the first match; tail insert, full-table reject, empty table and
// unused codes skip the walk.
// Throughput: one item at a time; the next beat is taken only after the result is loaded.
// Reset clears the entry count and control; table memory contents are not cleared.
module ordered_list_table_engine_top import olte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  olte_in_if.sink    req,
  olte_out_if.source rsp
);

  wr_port_t                 wr;
  rd_port_t                 rd;
  logic signed [DATA_W-1:0] rd_data;

  // operation sequencer
  olte_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // entry storage
  olte_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule

### dv/tb_ordered_list_table_engine_top.sv
// testbench for the ordered list table engine: random and directed beats checked against a table model
module tb_ordered_list_table_engine_top import olte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      WATCHDOG_LIMIT = 3000;
  localparam int      MAX_REPORTS    = 200;
  localparam int      RANDOM_ITEMS   = 800;
  localparam action_t ACT_SPARE6     = 3'd6;
  localparam action_t ACT_SPARE7     = 3'd7;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    logic [ENTRY_W-1:0]       count;
  } list_result_t;

  // table model plus queue of responses still owed by the block
  class list_scoreboard;
    logic signed [DATA_W-1:0] tbl [CAPACITY];
    int unsigned              cnt;
    list_result_t             pending_results[$];
    int                       errors;

    function new();
      cnt    = 0;
      errors = 0;
    endfunction

    function int unsigned find_first(logic signed [DATA_W-1:0] v);
      for (int unsigned i = 0; i < cnt; i++) begin
        if (tbl[i] == v) return i;
      end
      return cnt;
    endfunction

    // apply one accepted request beat to the table and queue its response
    function void note_request(action_t act, logic signed [DATA_W-1:0] item,
                               logic signed [DATA_W-1:0] refv);
      list_result_t r;
      int unsigned  p;
      int unsigned  i;
      r = '0;
      r.status = STAT_OK;
      case (act)
        ACT_HEAD, ACT_TAIL, ACT_AFTER, ACT_ORDERED: begin
          if (cnt >= CAPACITY) begin
            r.status = STAT_FULL;
          end else begin
            p = 0;
            if (act == ACT_TAIL) begin
              p = cnt;
            end else if (act == ACT_AFTER) begin
              i = find_first(refv);
              p = (i < cnt) ? i + 1 : cnt;
            end else if (act == ACT_ORDERED) begin
              // head if empty or below entry 0, else before first later entry not smaller
              if (cnt != 0 && !(item < tbl[0])) begin
                p = cnt;
                for (i = 1; i < cnt; i++) begin
                  if (!(item > tbl[i])) begin
                    p = i;
                    break;
                  end
                end
              end
            end
            for (i = cnt; i > p; i--) tbl[i] = tbl[i-1];
            tbl[p] = item;
            cnt++;
            r.pos = p[POS_W-1:0];
          end
        end
        ACT_REMOVE, ACT_SEARCH: begin
          i = find_first(item);
          if (i < cnt) begin
            r.value = tbl[i];
            r.pos   = i[POS_W-1:0];
            if (act == ACT_REMOVE) begin
              for (; i + 1 < cnt; i++) tbl[i] = tbl[i+1];
              cnt--;
            end
          end else begin
            r.status = STAT_MISS;
          end
        end
        default: begin
          r.status = STAT_MISS;
        end
      endcase
      r.count = cnt[ENTRY_W-1:0];
      pending_results.push_back(r);
    endfunction

    // compare one response beat with the oldest owed response
    function void check_response(status_t st, logic signed [DATA_W-1:0] val,
                                 logic [POS_W-1:0] pos, logic [ENTRY_W-1:0] n);
      list_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected response beat: status %0d value %0d position %0d count %0d",
                   $time, st, val, pos, n);
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
      end
      if (val !== e.value) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result_value mismatch: expected %0d actual %0d", $time, e.value, val);
      end
      if (pos !== e.pos) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: position mismatch: expected %0d actual %0d", $time, e.pos, pos);
      end
      if (n !== e.count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: entry_count mismatch: expected %0d actual %0d", $time, e.count, n);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  olte_in_if  req_if ();
  olte_out_if rsp_if ();

  list_scoreboard sb = new();

  ordered_list_table_engine_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // clock and known input values from time zero
  initial begin
    clk                    = 1'b0;
    rst                    = 1'b1;
    req_if.valid           = 1'b0;
    req_if.action          = ACT_HEAD;
    req_if.item_value      = '0;
    req_if.reference_value = '0;
    rsp_if.ready           = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length per beat, with stretches of no idling, of light idling and of full random idling
  function automatic int draw_gap(int unsigned idx);
    case ((idx / 37) % 4)
      0: return 0;
      2: return ($urandom_range(3, 0) == 0) ? $urandom_range(18, 0) : 0;
      default: return $urandom_range(18, 0);
    endcase
  endfunction

  // operand values: mostly a small pool so matches happen, some extremes and full range
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return $urandom;
    if (r < 22) return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom_range(16, 0) - 8;
  endfunction

  // an operand that usually matches something held in the table
  function automatic logic signed [DATA_W-1:0] pick_present();
    if (sb.cnt > 0 && $urandom_range(99, 0) < 80) return sb.tbl[$urandom_range(sb.cnt - 1, 0)];
    return pick_value();
  endfunction

  function automatic action_t random_insert_op();
    case ($urandom_range(3, 0))
      0: return ACT_HEAD;
      1: return ACT_TAIL;
      2: return ACT_AFTER;
      default: return ACT_ORDERED;
    endcase
  endfunction

  int unsigned beats_sent = 0;

  // offer one request beat, starting and ending at a falling edge
  task automatic send_beat(action_t act, logic signed [DATA_W-1:0] item,
                           logic signed [DATA_W-1:0] refv);
    int gap;
    gap = draw_gap(beats_sent);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.action          <= act;
    req_if.item_value      <= item;
    req_if.reference_value <= refv;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(act, item, refv);
    beats_sent++;
    @(negedge clk);
  endtask

  // stop offering until every owed response has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // response side: random holds, two long holds while requests keep coming
  initial begin : rsp_side
    int unsigned k;
    int          gap;
    k = 0;
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(k + 19);
      if (k == 250 || k == 650) gap = 300;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      sb.check_response(rsp_if.status, rsp_if.result_value, rsp_if.position,
                        rsp_if.entry_count);
      k++;
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // reset, directed beats, random beats, then drain and report
  initial begin : stimulus
    int                       n;
    int                       r;
    bit                       fill_phase;
    action_t                  act;
    logic signed [DATA_W-1:0] item;
    logic signed [DATA_W-1:0] refv;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table cases
    send_beat(ACT_SEARCH, 5, 0);
    send_beat(ACT_REMOVE, 5, 0);
    send_beat(ACT_AFTER, 9, 12);
    send_beat(ACT_REMOVE, 9, 0);
    send_beat(ACT_ORDERED, 4, 0);
    // extremes and insert kinds
    send_beat(ACT_HEAD, 32'sh7fffffff, 0);
    send_beat(ACT_TAIL, 32'sh80000000, 0);
    send_beat(ACT_AFTER, 3, 32'sh7fffffff);
    send_beat(ACT_AFTER, 6, 12345);
    send_beat(ACT_ORDERED, 32'sh80000000, 0);
    send_beat(ACT_ORDERED, 0, 0);
    send_beat(ACT_ORDERED, 3, 0);
    send_beat(ACT_ORDERED, 32'sh7fffffff, 0);
    send_beat(ACT_HEAD, 32'sh55555555, 32'shaaaaaaaa);
    send_beat(ACT_TAIL, 32'shaaaaaaaa, 32'sh55555555);
    send_beat(ACT_AFTER, 7, 32'shaaaaaaaa);
    // first match, misses, removals and unused codes
    send_beat(ACT_SEARCH, 3, 0);
    send_beat(ACT_SEARCH, 32'sh7fffffff, 0);
    send_beat(ACT_SEARCH, 777, 0);
    send_beat(ACT_REMOVE, 32'sh80000000, 0);
    send_beat(ACT_REMOVE, 999, 0);
    send_beat(ACT_REMOVE, 32'sh7fffffff, 0);
    send_beat(ACT_SPARE6, 3, 3);
    send_beat(ACT_SPARE7, 32'sh7fffffff, 32'sh80000000);

    // random beats in alternating fill and drain phases
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      fill_phase = ((n / 120) % 2) == 0;
      r = $urandom_range(99, 0);
      if (r < 2) begin
        act = $urandom_range(1, 0) ? ACT_SPARE6 : ACT_SPARE7;
      end else if (fill_phase) begin
        act = (r < 72) ? random_insert_op() : (r < 86) ? ACT_SEARCH : ACT_REMOVE;
      end else begin
        act = (r < 31) ? random_insert_op() : (r < 61) ? ACT_SEARCH : ACT_REMOVE;
      end
      item = (act == ACT_REMOVE || act == ACT_SEARCH) ? pick_present() : pick_value();
      refv = ($urandom_range(99, 0) < 70) ? pick_present() : $urandom;
      if (n == 400) wait_drained();
      send_beat(act, item, refv);
    end

    // drain and let any stray response show up
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (CAPACITY + 10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/olte_pkg.sv
rtl/olte_in_if.sv
rtl/olte_out_if.sv
rtl/olte_ram.sv
rtl/olte_ctrl.sv
rtl/ordered_list_table_engine_top.sv
dv/tb_ordered_list_table_engine_top.sv
